@@ hdl/nrps_pkg.sv @@
// Shared widths, codes and transfer structs for the nearest route point search block
`default_nettype none

package nrps_pkg;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 10;
    localparam int COORD_W = 32;
    localparam int FIRST_W = 16;
    localparam int LEN_W   = 11;
    localparam int KIND_W  = 4;
    localparam int ORDER_W = 15;
    localparam int CNT_W   = 14;
    localparam int NPTS_W  = 11;
    localparam int NPTH_W  = 5;
    localparam int DIST_W  = 2 * COORD_W + 1;
    localparam int PI_W    = 18;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [CNT_W-1:0]          ORDER_MAX  = '1;
    localparam logic signed [ORDER_W-1:0] ORDER_NONE = '1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_POINT = 2'd0,
        OP_LOAD_PATH  = 2'd1,
        OP_QUERY      = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        CMD_POINT = 2'd0,
        CMD_PATH  = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd_kind;

    typedef enum logic [1:0] {
        REG_NUM_POINTS   = 2'd0,
        REG_NUM_PATHS    = 2'd1,
        REG_FORWARD_KIND = 2'd2
    } t_reg;

    typedef struct packed {
        t_cmd_kind                   kind;
        logic [IDX_W-1:0]            idx;
        logic signed [COORD_W-1:0]   lon;
        logic signed [COORD_W-1:0]   lat;
        logic signed [FIRST_W-1:0]   first;
        logic [LEN_W-1:0]            length;
        logic [KIND_W-1:0]           path_kind;
    } t_cmd;

    typedef struct packed {
        logic [NPTS_W-1:0] num_points;
        logic [NPTH_W-1:0] num_paths;
        logic [KIND_W-1:0] forward_kind;
    } t_cfg;

    typedef struct packed {
        logic idle;
        logic pipe_empty;
    } t_bk_stat;

endpackage

`default_nettype wire

@@ hdl/nrps_if.sv @@
// Valid/ready channel interfaces for input items and query results
`default_nettype none

interface nrps_item_if import nrps_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic [IDX_W-1:0]          entry_index;
    logic signed [COORD_W-1:0] coord_lon;
    logic signed [COORD_W-1:0] coord_lat;
    logic signed [FIRST_W-1:0] in_first;
    logic [LEN_W-1:0]          in_length;
    logic [KIND_W-1:0]         in_kind;

    modport source (
        output valid, op, entry_index, coord_lon, coord_lat, in_first, in_length, in_kind,
        input  ready
    );
    modport sink (
        input  valid, op, entry_index, coord_lon, coord_lat, in_first, in_length, in_kind,
        output ready
    );
endinterface

interface nrps_result_if import nrps_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ORDER_W-1:0] near_order;

    modport source (output valid, near_order, input ready);
    modport sink (input valid, near_order, output ready);
endinterface

`default_nettype wire

@@ hdl/nearest_route_point_search.sv @@
// Nearest route point search: loads fill the point and path tables, a query returns the order.
// Loads are written into the tables when the back end pops them; a query walks the active paths
// and presents its result once the walk is done, the distance pipeline is empty and the output is free.
// Throughput: one walked point per cycle, bound by the single read port of the point memory.
// Reset: synchronous, active low; clears control, queue and register file; tables keep old data.
`default_nettype none

module nearest_route_point_search import nrps_pkg::*; #(
    parameter int POINT_DEPTH = 1024,
    parameter int PATH_DEPTH  = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    nrps_item_if.sink              i_item,
    nrps_result_if.source          o_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    t_cfg     cfg;
    t_cmd     cmd;
    logic     cmd_vld;
    logic     cmd_pop;
    t_bk_stat bk_stat;

    nrps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    nrps_front #(
        .POINT_DEPTH (POINT_DEPTH),
        .PATH_DEPTH  (PATH_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .o_cmd_vld (cmd_vld),
        .o_cmd     (cmd),
        .i_cmd_pop (cmd_pop)
    );

    nrps_back #(
        .POINT_DEPTH (POINT_DEPTH),
        .PATH_DEPTH  (PATH_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (cmd_vld),
        .i_cmd     (cmd),
        .o_cmd_pop (cmd_pop),
        .i_cfg     (cfg),
        .o_result  (o_result),
        .o_stat    (bk_stat)
    );

`ifndef SYNTH
    // a stalled input means the queue is full, so the back end must see a command
    a_stall_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> cmd_vld)
        else $error("input stalled with no queued command");

    // no distance work may be in flight once the sequencer is back to idle
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_stat.idle |-> bk_stat.pipe_empty)
        else $error("distance pipeline busy while sequencer idle");

    // a result is either none or a non-negative saturated order
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (!o_result.near_order[ORDER_W-1] || o_result.near_order == ORDER_NONE))
        else $error("result order out of range");

    // a command is only taken by an idle sequencer
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> (bk_stat.idle && cmd_vld))
        else $error("command popped while back end busy");
`endif

endmodule

`default_nettype wire

@@ hdl/nrps_cfg.sv @@
// APB register file: point count, path count and forward path kind
`default_nettype none

module nrps_cfg import nrps_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [NPTS_W-1:0] r_num_points;
    logic [NPTH_W-1:0] r_num_paths;
    logic [KIND_W-1:0] r_forward_kind;
    logic              wr_en;
    t_reg              reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg'(paddr[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points   <= '0;
            r_num_paths    <= '0;
            r_forward_kind <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_NUM_POINTS:   r_num_points   <= pwdata[NPTS_W-1:0];
                REG_NUM_PATHS:    r_num_paths    <= pwdata[NPTH_W-1:0];
                REG_FORWARD_KIND: r_forward_kind <= pwdata[KIND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_NUM_POINTS:   prdata = APB_DW'(r_num_points);
            REG_NUM_PATHS:    prdata = APB_DW'(r_num_paths);
            REG_FORWARD_KIND: prdata = APB_DW'(r_forward_kind);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.num_points   = r_num_points;
    assign o_cfg.num_paths    = r_num_paths;
    assign o_cfg.forward_kind = r_forward_kind;

endmodule

`default_nettype wire

@@ hdl/nrps_front.sv @@
// Front end: accepts items, drops ones with no effect, queues commands for the back end
`default_nettype none

module nrps_front import nrps_pkg::*; #(
    parameter int POINT_DEPTH,
    parameter int PATH_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    nrps_item_if.sink i_item,
    output logic      o_cmd_vld,
    output t_cmd      o_cmd,
    input  wire logic i_cmd_pop
);

    localparam int Q_DEPTH = 2;
    localparam int QPW     = $clog2(Q_DEPTH);
    localparam int QCW     = $clog2(Q_DEPTH + 1);

    t_cmd           r_q [Q_DEPTH];
    logic [QPW-1:0] r_wr;
    logic [QPW-1:0] r_rd;
    logic [QCW-1:0] r_count;
    logic [QPW-1:0] n_wr;
    logic [QPW-1:0] n_rd;
    t_cmd           n_cmd;
    logic           keep;
    logic           push;

    // loads beyond the table depth and the unused op code are swallowed here
    always_comb begin
        n_cmd.idx       = i_item.entry_index;
        n_cmd.lon       = i_item.coord_lon;
        n_cmd.lat       = i_item.coord_lat;
        n_cmd.first     = i_item.in_first;
        n_cmd.length    = i_item.in_length;
        n_cmd.path_kind = i_item.in_kind;
        case (i_item.op)
            OP_LOAD_POINT: begin
                n_cmd.kind = CMD_POINT;
                keep       = 32'(i_item.entry_index) < POINT_DEPTH;
            end
            OP_LOAD_PATH: begin
                n_cmd.kind = CMD_PATH;
                keep       = 32'(i_item.entry_index) < PATH_DEPTH;
            end
            OP_QUERY: begin
                n_cmd.kind = CMD_QUERY;
                keep       = 1'b1;
            end
            default: begin
                n_cmd.kind = CMD_QUERY;
                keep       = 1'b0;
            end
        endcase
    end

    assign i_item.ready = (r_count != QCW'(Q_DEPTH));
    assign push         = i_item.valid && i_item.ready && keep;
    assign n_wr         = (r_wr == QPW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd         = (r_rd == QPW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= n_wr;
            end
            if (i_cmd_pop) begin
                r_rd <= n_rd;
            end
            if (push && !i_cmd_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_cmd_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_cmd;
        end
    end

    assign o_cmd_vld = (r_count != '0);
    assign o_cmd     = r_q[r_rd];

endmodule

`default_nettype wire

@@ hdl/nrps_back.sv @@
// Back end: table memories, path walk sequencer, distance pipeline and result register
`default_nettype none

module nrps_back import nrps_pkg::*; #(
    parameter int POINT_DEPTH,
    parameter int PATH_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cmd_vld,
    input  wire t_cmd     i_cmd,
    output logic          o_cmd_pop,
    input  wire t_cfg     i_cfg,
    nrps_result_if.source o_result,
    output t_bk_stat      o_stat
);

    localparam int PA  = $clog2(POINT_DEPTH);
    localparam int PPA = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
    localparam int XW  = (PA > IDX_W) ? PA : IDX_W;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SCAN_RD  = 7'b0000010,
        ST_SCAN_CHK = 7'b0000100,
        ST_PATH_RD  = 7'b0001000,
        ST_PATH_CHK = 7'b0010000,
        ST_WALK     = 7'b0100000,
        ST_DRAIN    = 7'b1000000
    } t_state;

    typedef struct packed {
        logic signed [FIRST_W-1:0] first;
        logic [LEN_W-1:0]          length;
        logic [KIND_W-1:0]         kind;
    } t_path;

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        logic [COORD_W:0] d;
        logic [COORD_W:0] m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m[COORD_W-1:0];
    endfunction

    // tables
    logic [2*COORD_W-1:0] r_pmem [POINT_DEPTH];
    logic [2*COORD_W-1:0] r_pt_rd;
    t_path                r_path_mem [PATH_DEPTH];
    t_path                r_path_rd;

    // sequencer
    t_state                    r_state;
    t_state                    n_state;
    logic [PPA-1:0]            r_p;
    logic [PPA-1:0]            r_last_p;
    logic                      r_have_fwd;
    logic signed [COORD_W-1:0] r_q_lon;
    logic signed [COORD_W-1:0] r_q_lat;
    logic [PI_W-1:0]           r_pi;
    logic [LEN_W-1:0]          r_left;
    logic [CNT_W-1:0]          r_order;
    logic                      r_found;
    logic [DIST_W-1:0]         r_best_dist;
    logic [CNT_W-1:0]          r_best_ord;

    // distance pipeline
    logic               r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    logic               r_s1_in, r_s2_in, r_s3_in, r_s4_in;
    logic [CNT_W-1:0]   r_s1_ord, r_s2_ord, r_s3_ord, r_s4_ord;
    logic [COORD_W-1:0] r_s2_dx, r_s2_dy;
    logic [63:0]        r_s3_sx, r_s3_sy;
    logic [DIST_W-1:0]  r_s4_sum;

    // result register
    logic                      r_out_vld;
    logic signed [ORDER_W-1:0] r_out_order;

    logic            is_query;
    logic            empty_map;
    logic            last_path;
    logic            path_incl;
    logic            issue;
    logic            in_range;
    logic            pipe_empty;
    logic            out_free;
    logic            finish;
    logic [PI_W-2:0] pi_u;
    logic [XW-1:0]   idx_x;

    assign o_cmd_pop  = (r_state == ST_IDLE) && i_cmd_vld;
    assign is_query   = o_cmd_pop && (i_cmd.kind == CMD_QUERY);
    assign empty_map  = (i_cfg.num_points == '0) || (i_cfg.num_paths == '0);
    assign last_path  = (r_p == r_last_p);
    assign path_incl  = !r_have_fwd || (r_path_rd.kind == i_cfg.forward_kind);
    assign issue      = (r_state == ST_WALK) && (r_left != '0);
    assign pi_u       = r_pi[PI_W-2:0];
    assign in_range   = !r_pi[PI_W-1] && (pi_u < (PI_W-1)'(i_cfg.num_points))
                        && (32'(pi_u) < POINT_DEPTH);
    assign pipe_empty = !(r_s1_vld || r_s2_vld || r_s3_vld || r_s4_vld);
    assign out_free   = !r_out_vld || o_result.ready;
    assign finish     = (r_state == ST_DRAIN) && pipe_empty && out_free;
    assign idx_x      = XW'(i_cmd.idx);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (is_query) begin
                    n_state = empty_map ? ST_DRAIN : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:  n_state = ST_SCAN_CHK;
            ST_SCAN_CHK: n_state = last_path ? ST_PATH_RD : ST_SCAN_RD;
            ST_PATH_RD:  n_state = ST_PATH_CHK;
            ST_PATH_CHK: begin
                if (path_incl) begin
                    n_state = ST_WALK;
                end else begin
                    n_state = last_path ? ST_DRAIN : ST_PATH_RD;
                end
            end
            ST_WALK: begin
                if (r_left == '0) begin
                    n_state = last_path ? ST_DRAIN : ST_PATH_RD;
                end
            end
            ST_DRAIN: begin
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memories: one write port each, registered read
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && (i_cmd.kind == CMD_POINT)) begin
            r_pmem[idx_x[PA-1:0]] <= {i_cmd.lon, i_cmd.lat};
        end
        r_pt_rd <= r_pmem[r_pi[PA-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && (i_cmd.kind == CMD_PATH)) begin
            r_path_mem[i_cmd.idx[PPA-1:0]] <= '{first: i_cmd.first, length: i_cmd.length,
                                                kind: i_cmd.path_kind};
        end
        r_path_rd <= r_path_mem[r_p];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_found   <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            if (is_query) begin
                r_found <= 1'b0;
            end else if (r_s4_vld && r_s4_in) begin
                r_found <= 1'b1;
            end
            if (finish) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // walk datapath
    always_ff @(posedge i_clk) begin
        if (is_query) begin
            r_q_lon    <= i_cmd.lon;
            r_q_lat    <= i_cmd.lat;
            r_have_fwd <= 1'b0;
            r_order    <= '0;
            r_p        <= '0;
            r_last_p   <= (32'(i_cfg.num_paths) >= PATH_DEPTH) ? PPA'(PATH_DEPTH - 1)
                                                                : PPA'(i_cfg.num_paths - 5'd1);
        end
        case (r_state)
            ST_SCAN_CHK: begin
                if (r_path_rd.kind == i_cfg.forward_kind) begin
                    r_have_fwd <= 1'b1;
                end
                r_p <= last_path ? '0 : r_p + 1'b1;
            end
            ST_PATH_CHK: begin
                if (path_incl) begin
                    r_pi   <= {{(PI_W-FIRST_W){r_path_rd.first[FIRST_W-1]}}, r_path_rd.first};
                    r_left <= r_path_rd.length;
                end else if (!last_path) begin
                    r_p <= r_p + 1'b1;
                end
            end
            ST_WALK: begin
                if (r_left != '0) begin
                    r_pi    <= r_pi + 1'b1;
                    r_left  <= r_left - 1'b1;
                    r_order <= (r_order == ORDER_MAX) ? r_order : r_order + 1'b1;
                end else if (!last_path) begin
                    r_p <= r_p + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // distance pipeline: read, abs difference, square, sum, compare
    always_ff @(posedge i_clk) begin
        r_s1_in  <= in_range;
        r_s1_ord <= r_order;

        r_s2_in  <= r_s1_in;
        r_s2_ord <= r_s1_ord;
        r_s2_dx  <= abs_diff(r_pt_rd[2*COORD_W-1:COORD_W], r_q_lon);
        r_s2_dy  <= abs_diff(r_pt_rd[COORD_W-1:0], r_q_lat);

        r_s3_in  <= r_s2_in;
        r_s3_ord <= r_s2_ord;
        r_s3_sx  <= r_s2_dx * r_s2_dx;
        r_s3_sy  <= r_s2_dy * r_s2_dy;

        r_s4_in  <= r_s3_in;
        r_s4_ord <= r_s3_ord;
        r_s4_sum <= {1'b0, r_s3_sx} + {1'b0, r_s3_sy};

        // strict compare keeps the earliest point on a tie
        if (r_s4_vld && r_s4_in && (!r_found || (r_s4_sum < r_best_dist))) begin
            r_best_dist <= r_s4_sum;
            r_best_ord  <= r_s4_ord;
        end

        if (finish) begin
            r_out_order <= r_found ? $signed({1'b0, r_best_ord}) : ORDER_NONE;
        end
    end

    assign o_result.valid      = r_out_vld;
    assign o_result.near_order = r_out_order;

    assign o_stat.idle       = (r_state == ST_IDLE);
    assign o_stat.pipe_empty = pipe_empty;

endmodule

`default_nettype wire

@@ sim/tb_nearest_route_point_search.sv @@
// Testbench for nearest_route_point_search: table loads and queries checked against a local model
`default_nettype none

module tb_nearest_route_point_search import nrps_pkg::*; ();

    localparam int POINT_DEPTH   = 1024;
    localparam int PATH_DEPTH    = 16;
    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 64;
    localparam int QUIET_LIMIT   = 200000;
    localparam int PHASES        = 8;
    localparam int DIR_N         = 22;

    localparam logic [OP_W-1:0]           OP_IGNORED = 2'd3;
    localparam logic signed [COORD_W-1:0] C_MAX      = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] C_MIN      = 32'sh8000_0000;

    typedef struct packed {
        bit                        setcfg;
        t_cfg                      cfg;
        logic [OP_W-1:0]           op;
        logic [IDX_W-1:0]          idx;
        logic signed [COORD_W-1:0] lon;
        logic signed [COORD_W-1:0] lat;
        logic signed [FIRST_W-1:0] first;
        logic [LEN_W-1:0]          len;
        logic [KIND_W-1:0]         kind;
        bit                        typed;
        logic signed [ORDER_W-1:0] order;
    } t_row;

    localparam t_cfg NO_CFG = '0;

    // directed rows; order typed in only where it is obvious
    localparam t_row PLAN [DIR_N] = '{
        '{1'b1, '{11'd0, 5'd0, 4'd0}, OP_QUERY, 10'd0, 32'sd0, 32'sd0,
          16'sd0, 11'd0, 4'd0, 1'b1, ORDER_NONE},
        '{1'b0, NO_CFG, OP_LOAD_POINT, 10'd0, 32'sd0, 32'sd0, 16'sd0, 11'd0, 4'd0, 1'b0, 15'sd0},
        '{1'b0, NO_CFG, OP_LOAD_POINT, 10'd1, C_MAX, C_MAX, 16'sd0, 11'd0, 4'd0, 1'b0, 15'sd0},
        '{1'b0, NO_CFG, OP_LOAD_POINT, 10'd2, C_MIN, C_MIN, 16'sd0, 11'd0, 4'd0, 1'b0, 15'sd0},
        '{1'b0, NO_CFG, OP_LOAD_POINT, 10'd3, 32'sd0, 32'sd0, 16'sd0, 11'd0, 4'd0, 1'b0, 15'sd0},
        '{1'b0, NO_CFG, OP_LOAD_POINT, 10'd1023, C_MAX, C_MIN,
          16'sd0, 11'd0, 4'd0, 1'b0, 15'sd0},
        '{1'b0, NO_CFG, OP_LOAD_PATH, 10'd0, 32'sd0, 32'sd0, 16'sd0, 11'd4, 4'd3, 1'b0, 15'sd0},
        '{1'b0, NO_CFG, OP_LOAD_PATH, 10'd1, 32'sd0, 32'sd0, -16'sd2, 11'd3, 4'd5, 1'b0, 15'sd0},
        // beyond the path table: dropped
        '{1'b0, NO_CFG, OP_LOAD_PATH, 10'd20, 32'sd0, 32'sd0,
          16'sd0, 11'd2047, 4'd15, 1'b0, 15'sd0},
        '{1'b0, NO_CFG, OP_IGNORED, 10'd1023, C_MIN, C_MAX,
          -16'sd1, 11'd2047, 4'd15, 1'b0, 15'sd0},
        '{1'b1, '{11'd4, 5'd0, 4'd0}, OP_QUERY, 10'd0, 32'sd0, 32'sd0,
          16'sd0, 11'd0, 4'd0, 1'b1, ORDER_NONE},
        // points 0 and 3 tie at zero distance, first one wins
        '{1'b1, '{11'd4, 5'd2, 4'd0}, OP_QUERY, 10'd0, 32'sd0, 32'sd0,
          16'sd0, 11'd0, 4'd0, 1'b1, 15'sd0},
        '{1'b0, NO_CFG, OP_QUERY, 10'd0, C_MAX, C_MAX, 16'sd0, 11'd0, 4'd0, 1'b1, 15'sd1},
        '{1'b0, NO_CFG, OP_QUERY, 10'd0, C_MIN, C_MIN, 16'sd0, 11'd0, 4'd0, 1'b1, 15'sd2},
        '{1'b0, NO_CFG, OP_QUERY, 10'd0, C_MAX, C_MIN, 16'sd0, 11'd0, 4'd0, 1'b0, 15'sd0},
        // forward kind 5: only path 1, two skipped indices before point 0
        '{1'b1, '{11'd4, 5'd2, 4'd5}, OP_QUERY, 10'd0, C_MAX, C_MAX,
          16'sd0, 11'd0, 4'd0, 1'b1, 15'sd2},
        '{1'b1, '{11'd1, 5'd2, 4'd3}, OP_QUERY, 10'd0, C_MIN, C_MIN,
          16'sd0, 11'd0, 4'd0, 1'b1, 15'sd0},
        '{1'b0, NO_CFG, OP_LOAD_PATH, 10'd15, 32'sd0, 32'sd0,
          16'sd32767, 11'd2047, 4'd15, 1'b0, 15'sd0},
        '{1'b0, NO_CFG, OP_LOAD_POINT, 10'd4, 32'sd1, -32'sd1,
          16'sd0, 11'd0, 4'd0, 1'b0, 15'sd0},
        '{1'b0, NO_CFG, OP_QUERY, 10'd0, 32'sd1, -32'sd1, 16'sd0, 11'd0, 4'd0, 1'b0, 15'sd0},
        '{1'b0, NO_CFG, OP_LOAD_PATH, 10'd1, 32'sd0, 32'sd0, 16'sd0, 11'd0, 4'd5, 1'b0, 15'sd0},
        // forward path is empty: nothing found
        '{1'b1, '{11'd4, 5'd2, 4'd5}, OP_QUERY, 10'd0, 32'sd0, 32'sd0,
          16'sd0, 11'd0, 4'd0, 1'b1, ORDER_NONE}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    nrps_item_if   item_ch ();
    nrps_result_if res_ch ();

    nearest_route_point_search uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // local copy of the route map and registers
    logic signed [COORD_W-1:0] map_lon [POINT_DEPTH];
    logic signed [COORD_W-1:0] map_lat [POINT_DEPTH];
    bit                        map_loaded [POINT_DEPTH];
    logic signed [FIRST_W-1:0] route_first [PATH_DEPTH];
    logic [LEN_W-1:0]          route_len [PATH_DEPTH];
    logic [KIND_W-1:0]         route_kind [PATH_DEPTH];
    bit                        route_loaded [PATH_DEPTH];
    t_cfg                      regs;

    logic signed [ORDER_W-1:0] pending_orders [$];
    logic signed [ORDER_W-1:0] due;
    int                        errors = 0;
    int                        quiet_cycles = 0;
    bit                        quiet = 1'b0;

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // Walks the included paths like the block does. Also reports the first table entry the
    // walk would read before it was ever loaded.
    function automatic logic signed [ORDER_W-1:0] nearest_order(
        input  logic signed [COORD_W-1:0] lon,
        input  logic signed [COORD_W-1:0] lat,
        output bit                        hole,
        output bit                        hole_path,
        output int                        hole_at
    );
        int              npts;
        int              npth;
        int              pos;
        int              cur;
        int              pi;
        int              best;
        bit              fwd_seen;
        bit              found;
        longint          dx;
        longint          dy;
        logic [DIST_W:0] ax;
        logic [DIST_W:0] ay;
        logic [DIST_W:0] d;
        logic [DIST_W:0] best_d;
        hole      = 1'b0;
        hole_path = 1'b0;
        hole_at   = 0;
        npts      = (regs.num_points < POINT_DEPTH) ? int'(regs.num_points) : POINT_DEPTH;
        npth      = (regs.num_paths < PATH_DEPTH) ? int'(regs.num_paths) : PATH_DEPTH;
        fwd_seen  = 1'b0;
        found     = 1'b0;
        pos       = 0;
        best      = 0;
        best_d    = '0;
        if (npts == 0 || npth == 0) begin
            return ORDER_NONE;
        end
        for (int p = 0; p < npth; p++) begin
            if (!route_loaded[p] && !hole) begin
                hole      = 1'b1;
                hole_path = 1'b1;
                hole_at   = p;
            end
            if (route_kind[p] == regs.forward_kind) begin
                fwd_seen = 1'b1;
            end
        end
        for (int p = 0; p < npth; p++) begin
            if (fwd_seen && route_kind[p] != regs.forward_kind) begin
                continue;
            end
            for (int j = 0; j < int'(route_len[p]); j++) begin
                pi  = int'(route_first[p]) + j;
                cur = pos;
                if (pos < int'(ORDER_MAX)) begin
                    pos++;
                end
                if (pi >= 0 && pi < npts) begin
                    if (!map_loaded[pi] && !hole) begin
                        hole    = 1'b1;
                        hole_at = pi;
                    end
                    dx = longint'(map_lon[pi]) - longint'(lon);
                    dy = longint'(map_lat[pi]) - longint'(lat);
                    if (dx < 0) begin
                        dx = -dx;
                    end
                    if (dy < 0) begin
                        dy = -dy;
                    end
                    ax = (DIST_W + 1)'(dx);
                    ay = (DIST_W + 1)'(dy);
                    d  = ax * ax + ay * ay;
                    if (!found || d < best_d) begin
                        found  = 1'b1;
                        best_d = d;
                        best   = cur;
                    end
                end
            end
        end
        return found ? ORDER_W'(best) : ORDER_NONE;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // mostly short paths near the loaded points, a few long ones entirely out of range
    task automatic make_path(
        output logic signed [FIRST_W-1:0] first,
        output logic [LEN_W-1:0]          len,
        output logic [KIND_W-1:0]         kind
    );
        int u;
        u = $urandom_range(0, 99);
        if ($urandom_range(0, 4) < 3) begin
            kind = KIND_W'($urandom_range(0, 3));
        end else begin
            kind = KIND_W'($urandom);
        end
        if (u < 93) begin
            first = FIRST_W'(int'($urandom_range(0, 48)) - 8);
            len   = LEN_W'($urandom_range(0, 12));
        end else begin
            len = LEN_W'($urandom);
            if ($urandom_range(0, 1) == 0) begin
                first = FIRST_W'(-int'($urandom_range(2048, 32768)));
            end else begin
                first = FIRST_W'($urandom_range(1024, 32767));
            end
        end
    endtask

    task automatic pick_item(output t_row r);
        int u;
        int k;
        r       = '0;
        r.idx   = IDX_W'($urandom);
        r.lon   = COORD_W'($urandom);
        r.lat   = COORD_W'($urandom);
        r.first = FIRST_W'($urandom);
        r.len   = LEN_W'($urandom);
        r.kind  = KIND_W'($urandom);
        u       = $urandom_range(0, 99);
        k       = $urandom_range(0, 63);
        if (u < 40) begin
            r.op = OP_QUERY;
            if ($urandom_range(0, 2) == 0 && map_loaded[k]) begin
                r.lon = map_lon[k];
                r.lat = map_lat[k];
            end
        end else if (u < 65) begin
            r.op = OP_LOAD_POINT;
            if ($urandom_range(0, 1) == 0) begin
                r.idx = IDX_W'($urandom_range(0, 63));
            end
            u = $urandom_range(0, 9);
            if (u < 2 && map_loaded[k]) begin
                // duplicate coordinates make distance ties
                r.lon = map_lon[k];
                r.lat = map_lat[k];
            end else if (u < 5) begin
                r.lon = COORD_W'(int'($urandom_range(0, 2000)) - 1000);
                r.lat = COORD_W'(int'($urandom_range(0, 2000)) - 1000);
            end
        end else if (u < 92) begin
            r.op  = OP_LOAD_PATH;
            r.idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(PATH_DEPTH, 1023))
                                                : IDX_W'($urandom_range(0, PATH_DEPTH - 1));
            make_path(r.first, r.len, r.kind);
        end else begin
            r.op = OP_IGNORED;
        end
    endtask

    task automatic send_item(input t_row r);
        int                        gap;
        bit                        hole;
        bit                        hole_path;
        int                        hole_at;
        logic signed [ORDER_W-1:0] want;
        gap = pick_gap();
        if (gap != 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.op          <= r.op;
        item_ch.entry_index <= r.idx;
        item_ch.coord_lon   <= r.lon;
        item_ch.coord_lat   <= r.lat;
        item_ch.in_first    <= r.first;
        item_ch.in_length   <= r.len;
        item_ch.in_kind     <= r.kind;
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
        case (r.op)
            OP_LOAD_POINT: begin
                map_lon[r.idx]    = r.lon;
                map_lat[r.idx]    = r.lat;
                map_loaded[r.idx] = 1'b1;
            end
            OP_LOAD_PATH: begin
                if (r.idx < PATH_DEPTH) begin
                    route_first[r.idx]  = r.first;
                    route_len[r.idx]    = r.len;
                    route_kind[r.idx]   = r.kind;
                    route_loaded[r.idx] = 1'b1;
                end
            end
            OP_QUERY: begin
                want = nearest_order(r.lon, r.lat, hole, hole_path, hole_at);
                pending_orders.push_back(r.typed ? r.order : want);
            end
            default: ;
        endcase
    endtask

    // sender goes idle until every query has been answered
    task automatic wait_results();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_orders.size() != 0);
    endtask

    task automatic apb_write(input t_reg r, input logic [APB_DW-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
    endtask

    // loads can still sit in the block after the last answer, so let it settle first
    task automatic program_regs(input t_cfg c);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        apb_write(REG_NUM_POINTS, APB_DW'(c.num_points));
        apb_write(REG_NUM_PATHS, APB_DW'(c.num_paths));
        apb_write(REG_FORWARD_KIND, APB_DW'(c.forward_kind));
        psel    <= 1'b0;
        penable <= 1'b0;
        regs = c;
    endtask

    // result side: random back-pressure
    initial begin
        int hold;
        hold = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold != 0) begin
                res_ch.ready <= 1'b0;
                hold--;
            end else begin
                res_ch.ready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (pending_orders.size() == 0) begin
                $display("%0t: near_order %0d with no query waiting", $time, res_ch.near_order);
                errors++;
            end else begin
                due = pending_orders.pop_front();
                if (res_ch.near_order !== due) begin
                    $display("%0t: near_order mismatch, expected %0d, actual %0d",
                             $time, due, res_ch.near_order);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("tb_nearest_route_point_search failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_row                      r;
        t_cfg                      c;
        int                        per;
        bit                        hole;
        bit                        hole_path;
        int                        hole_at;
        logic [KIND_W-1:0]         fk;
        logic signed [ORDER_W-1:0] unused;
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        item_ch.valid       <= 1'b0;
        item_ch.op          <= '0;
        item_ch.entry_index <= '0;
        item_ch.coord_lon   <= '0;
        item_ch.coord_lat   <= '0;
        item_ch.in_first    <= '0;
        item_ch.in_length   <= '0;
        item_ch.in_kind     <= '0;
        regs = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++) begin
            if (PLAN[i].setcfg) begin
                program_regs(PLAN[i].cfg);
            end
            send_item(PLAN[i]);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: c = '{NPTS_W'(2047), NPTH_W'(31), KIND_W'($urandom_range(0, 3))};
                1: c = '{'0, NPTH_W'($urandom_range(1, PATH_DEPTH)), KIND_W'($urandom)};
                2: c = '{NPTS_W'($urandom_range(1, 64)), '0, KIND_W'($urandom)};
                3: c = '{NPTS_W'(POINT_DEPTH), NPTH_W'(PATH_DEPTH), '0};
                default: c = '{NPTS_W'($urandom_range(1, 64)),
                               NPTH_W'($urandom_range(1, PATH_DEPTH)),
                               KIND_W'($urandom)};
            endcase
            program_regs(c);
            quiet <= (ph % 3 == 2);
            per = (ph == 1 || ph == 2) ? 20 : 85;
            for (int n = 0; n < per; n++) begin
                if (ph == 4 && n == per / 2) begin
                    wait_results();
                end
                pick_item(r);
                if (r.op == OP_QUERY) begin
                    unused = nearest_order(r.lon, r.lat, hole, hole_path, hole_at);
                    // fill the entry the query would read first instead of sending it now
                    if (hole) begin
                        r.idx = IDX_W'(hole_at);
                        if (hole_path) begin
                            r.op = OP_LOAD_PATH;
                            make_path(r.first, r.len, r.kind);
                        end else begin
                            r.op = OP_LOAD_POINT;
                        end
                    end
                end
                send_item(r);
            end
        end

        // order counter saturation: long out-of-range paths ahead of a short real one
        fk = KIND_W'($urandom);
        program_regs('{NPTS_W'(64), NPTH_W'(PATH_DEPTH), fk});
        quiet <= 1'b0;
        for (int p = 0; p < PATH_DEPTH; p++) begin
            r      = '0;
            r.op   = OP_LOAD_PATH;
            r.idx  = IDX_W'(p);
            r.kind = fk;
            if (p < PATH_DEPTH - 1) begin
                r.first = 16'sh8000;
                r.len   = '1;
            end else begin
                r.len = LEN_W'(3);
            end
            send_item(r);
        end
        for (int q = 0; q < 3; q++) begin
            r     = '0;
            r.op  = OP_QUERY;
            r.lon = COORD_W'($urandom);
            r.lat = COORD_W'($urandom);
            send_item(r);
        end

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_nearest_route_point_search passed");
        end else begin
            $display("tb_nearest_route_point_search failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ nearest_route_point_search.f @@
hdl/nrps_pkg.sv
hdl/nrps_if.sv
hdl/nrps_cfg.sv
hdl/nrps_front.sv
hdl/nrps_back.sv
hdl/nearest_route_point_search.sv
sim/tb_nearest_route_point_search.sv
